FILE: src/primitive_index_assembler_top_assert.svh
// ----------------------------------------------------------------------------
// primitive index assembler assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_INDEX_ASSEMBLER_TOP_ASSERT_SVH
`define PRIMITIVE_INDEX_ASSEMBLER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PIA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("primitive index assembler: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("primitive index assembler: next-cycle check failed");

`endif

FILE: src/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg
// shared types, constants and helpers of the primitive index assembler
// ----------------------------------------------------------------------------
package pia_pkg;

  // width of the index fields on the ports
  localparam int FieldBits  = 32;
  // bits of an index that are kept and compared
  localparam int IndexBits  = 32;
  // face mode register width
  localparam int ModeBits   = 2;
  // triangles one item can cause
  localparam int MaxResults = 2;
  localparam int CountBits  = $clog2(MaxResults + 1);
  // result queue sizing
  localparam int QDepth     = 8;
  localparam int QPtrBits   = $clog2(QDepth);
  localparam int QCntBits   = $clog2(QDepth + 1);
  // held index slots
  localparam int HeldSlots  = 3;
  localparam int PosBits    = 2;

  typedef enum logic [ModeBits-1:0] {
    ModeList  = 2'd0,
    ModeStrip = 2'd1,
    ModeQuad  = 2'd2,
    ModeNone  = 2'd3
  } pia_mode_e;

  typedef struct packed {
    logic [IndexBits-1:0] vertex;
    logic                 list_start;
  } pia_item_t;

  typedef struct packed {
    logic [FieldBits-1:0] corner_first;
    logic [FieldBits-1:0] corner_second;
    logic [FieldBits-1:0] corner_third;
    logic                 run_last;
  } pia_tri_t;

  // triangles produced by one item, first one goes out first
  typedef struct packed {
    logic [CountBits-1:0] count;
    pia_tri_t             first_tri;
    pia_tri_t             second_tri;
  } pia_push_t;

  function automatic pia_tri_t pia_make_tri(input logic [IndexBits-1:0] a,
                                            input logic [IndexBits-1:0] b,
                                            input logic [IndexBits-1:0] c,
                                            input logic             last);
    pia_tri_t t;
    t.corner_first  = FieldBits'(a);
    t.corner_second = FieldBits'(b);
    t.corner_third  = FieldBits'(c);
    t.run_last      = last;
    return t;
  endfunction

endpackage

FILE: src/pia_in_if.sv
// ----------------------------------------------------------------------------
// pia_in_if
// index item channel: valid/ready with vertex index and list start
// ----------------------------------------------------------------------------
interface pia_in_if;
  logic                            valid;
  logic                            ready;
  logic [pia_pkg::FieldBits-1:0]   vertex_index;
  logic                            list_start;

  modport source (output valid, output vertex_index, output list_start, input ready);
  modport sink (input valid, input vertex_index, input list_start, output ready);
endinterface

FILE: src/pia_out_if.sv
// ----------------------------------------------------------------------------
// pia_out_if
// triangle item channel: valid/ready with three corners and run last
// ----------------------------------------------------------------------------
interface pia_out_if;
  logic                            valid;
  logic                            ready;
  logic [pia_pkg::FieldBits-1:0]   corner_first;
  logic [pia_pkg::FieldBits-1:0]   corner_second;
  logic [pia_pkg::FieldBits-1:0]   corner_third;
  logic                            run_last;

  modport source (output valid, output corner_first, output corner_second,
                  output corner_third, output run_last, input ready);
  modport sink (input valid, input corner_first, input corner_second,
                input corner_third, input run_last, output ready);
endinterface

FILE: src/primitive_index_assembler_top.sv
// ----------------------------------------------------------------------------
// primitive_index_assembler_top
// vertex index stream to triangles in list, strip or quad face mode
// ----------------------------------------------------------------------------
// usage
//   in_i carries one vertex index per item with a list start flag; out_o
//   carries triangles of three corners, run_last marks the last
//   triangle caused by one index item. cfg_we_i/cfg_data_i write face_mode
//   (0 list, 1 strip, 2 quads, 3 emits nothing); the user must write it only
//   while the block is idle, which the block itself does not enforce. an
//   accepted index item passes the input register and the result queue before
//   it leaves as a triangle. throughput: one index item per cycle while ready
//   is high; a quad's second triangle leaves after the first while the next
//   index is already taken in. ready is held off when the 8-entry result queue
//   lacks room for the item in the input register plus two more triangles.
//   reset clears group position, sets the winding to counter-clockwise first,
//   sets face_mode to list and empties the queue; held indices need a write.
//   when the receiver stalls, the queue head holds steady and the queue fills
//   until ready drops; no item is lost.
// ----------------------------------------------------------------------------
module primitive_index_assembler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pia_in_if.sink                         in_i,
  pia_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [pia_pkg::ModeBits-1:0]   cfg_data_i
);
  import pia_pkg::*;

  pia_mode_e            face_mode_q;
  logic                 stage_valid_q;
  pia_item_t            stage_item_q;
  pia_push_t            push;
  logic [QCntBits-1:0]  free;
  logic                 in_fire;

  // room for the staged item's triangles plus a worst case item
  assign in_i.ready = (free >= QCntBits'(QCntBits'(push.count) + QCntBits'(MaxResults)));
  assign in_fire    = in_i.valid && in_i.ready;

  // face mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_mode_q <= ModeList;
    end else if (cfg_we_i) begin
      face_mode_q <= pia_mode_e'(cfg_data_i);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_item_q.vertex     <= in_i.vertex_index[IndexBits-1:0];
      stage_item_q.list_start <= in_i.list_start;
    end
  end

  pia_assemble u_assemble (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid_q),
    .item_i       (stage_item_q),
    .face_mode_i  (face_mode_q),
    .push_o       (push)
  );

  pia_result_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

FILE: src/pia_assemble.sv
// ----------------------------------------------------------------------------
// pia_assemble
// group state and triangle forming for one registered index item per cycle
// ----------------------------------------------------------------------------
module pia_assemble (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  pia_pkg::pia_item_t  item_i,
  input  pia_pkg::pia_mode_e  face_mode_i,
  output pia_pkg::pia_push_t  push_o
);
  import pia_pkg::*;

  logic [IndexBits-1:0] held_q [HeldSlots];
  logic [PosBits-1:0]   pos_q, pos_d, pos_eff;
  logic                 wind_q, wind_d, wind_eff;
  logic [HeldSlots-1:0] held_we;
  logic                 shift_win;
  logic                 distinct;
  logic [IndexBits-1:0] v;
  pia_push_t            push;

  assign v = item_i.vertex;

  // strip triangles with a repeated corner are dropped
  assign distinct = (held_q[0] != held_q[1]) && (held_q[1] != v) && (v != held_q[0]);

  // triangle forming and next group state
  always_comb begin
    pos_eff         = item_i.list_start ? '0 : pos_q;
    wind_eff        = item_i.list_start ? 1'b1 : wind_q;
    pos_d           = pos_eff;
    wind_d          = wind_eff;
    held_we         = '0;
    shift_win       = 1'b0;
    push.count      = '0;
    push.first_tri  = pia_make_tri(held_q[0], held_q[1], v, 1'b1);
    push.second_tri = pia_make_tri(held_q[2], held_q[0], v, 1'b1);
    case (face_mode_i)
      ModeList: begin
        if (pos_eff >= PosBits'(2)) begin
          push.count = CountBits'(1);
          pos_d      = '0;
        end else begin
          held_we = HeldSlots'(4'b0001 << pos_eff);
          pos_d   = PosBits'(pos_eff + PosBits'(1));
        end
      end
      ModeStrip: begin
        if (pos_eff < PosBits'(2)) begin
          held_we = HeldSlots'(4'b0001 << pos_eff);
          pos_d   = PosBits'(pos_eff + PosBits'(1));
        end else begin
          if (distinct) begin
            push.count = CountBits'(1);
          end
          if (wind_eff) begin
            push.first_tri = pia_make_tri(held_q[0], v, held_q[1], 1'b1);
          end
          shift_win = 1'b1;
          pos_d     = PosBits'(2);
          wind_d    = ~wind_eff;
        end
      end
      ModeQuad: begin
        if (pos_eff == PosBits'(3)) begin
          push.count     = CountBits'(2);
          push.first_tri = pia_make_tri(held_q[0], held_q[2], held_q[1], 1'b0);
          pos_d          = '0;
        end else begin
          held_we = HeldSlots'(4'b0001 << pos_eff);
          pos_d   = PosBits'(pos_eff + PosBits'(1));
        end
      end
      default: begin
      end
    endcase
    if (!item_valid_i) begin
      push.count = '0;
    end
  end

  assign push_o = push;

  // group position and winding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wind_q <= 1'b1;
    end else if (item_valid_i) begin
      pos_q  <= pos_d;
      wind_q <= wind_d;
    end
  end

  // held indices, sliding window in strip mode
  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      if (shift_win) begin
        held_q[0] <= held_q[1];
        held_q[1] <= v;
      end else begin
        for (int i = 0; i < HeldSlots; i++) begin
          if (held_we[i]) begin
            held_q[i] <= v;
          end
        end
      end
    end
  end

endmodule

FILE: src/pia_result_queue.sv
// ----------------------------------------------------------------------------
// pia_result_queue
// triangle queue, up to two items in per cycle, one out per cycle when ready
// ----------------------------------------------------------------------------
module pia_result_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pia_pkg::pia_push_t               push_i,
  output logic [pia_pkg::QCntBits-1:0]     free_o,
  pia_out_if.source                        out_o
);
  import pia_pkg::*;

  pia_tri_t             mem_q [QDepth];
  logic [QPtrBits-1:0]  wr_q, rd_q;
  logic [QCntBits-1:0]  cnt_q, cnt_d;
  logic                 pop;
  pia_tri_t             head;

  assign pop  = out_o.valid && out_o.ready;
  assign head = mem_q[rd_q];

  // head item to the port
  assign out_o.valid         = (cnt_q != '0);
  assign out_o.corner_first  = head.corner_first;
  assign out_o.corner_second = head.corner_second;
  assign out_o.corner_third  = head.corner_third;
  assign out_o.run_last      = head.run_last;

  assign free_o = QCntBits'(QDepth) - cnt_q;
  assign cnt_d  = QCntBits'(cnt_q + QCntBits'(push_i.count) - QCntBits'(pop));

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= QPtrBits'(wr_q + QPtrBits'(push_i.count));
      rd_q  <= QPtrBits'(rd_q + QPtrBits'(pop));
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != '0) begin
      mem_q[wr_q] <= push_i.first_tri;
    end
    if (push_i.count == CountBits'(2)) begin
      mem_q[QPtrBits'(wr_q + QPtrBits'(1))] <= push_i.second_tri;
    end
  end

endmodule

FILE: src/pia_checker.sv
// ----------------------------------------------------------------------------
// pia_checker
// port-level checks of the primitive index assembler, bound to the top level
// ----------------------------------------------------------------------------
`include "primitive_index_assembler_top_assert.svh"

module pia_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [pia_pkg::FieldBits-1:0]  corner_first_i,
  input logic [pia_pkg::FieldBits-1:0]  corner_second_i,
  input logic [pia_pkg::FieldBits-1:0]  corner_third_i,
  input logic                           run_last_i
);
  logic out_take;
  logic pair_first;

  assign out_take   = out_valid_i && out_ready_i;
  assign pair_first = out_take && !run_last_i;

  // stalled triangle holds
  `PIA_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(corner_first_i) && $stable(corner_second_i)
                   && $stable(corner_third_i) && $stable(run_last_i))

  // first quad triangle is followed at once by the closing one
  `PIA_ASSERT_NEXT(a_pair_follows, pair_first, out_valid_i && run_last_i)

  // second quad triangle swaps the first two corners of the first
  `PIA_ASSERT_NEXT(a_pair_corners, pair_first,
                   corner_first_i == $past(corner_second_i)
                   && corner_second_i == $past(corner_first_i))

endmodule

bind primitive_index_assembler_top pia_checker u_pia_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .corner_first_i  (out_o.corner_first),
  .corner_second_i (out_o.corner_second),
  .corner_third_i  (out_o.corner_third),
  .run_last_i      (out_o.run_last)
);

FILE: tb/pia_triangle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pia_triangle_checker
// watches the index and triangle channels and the face mode writes, works out
// the triangles each accepted index item should cause and compares every
// accepted triangle item field by field with the oldest one still expected
// ----------------------------------------------------------------------------
module pia_triangle_checker
  import pia_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  pia_in_if                   index_i,
  pia_out_if                  triangle_i,
  input  logic                cfg_we_i,
  input  logic [ModeBits-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // shadow of the assembler state
  pia_mode_e            face_mode;
  logic [IndexBits-1:0] held [HeldSlots];
  logic [PosBits-1:0]   slot_pos;
  logic                 winding_ccw;

  // triangles still owed by the block, oldest first
  pia_tri_t             tri_expected_q [$];

  // append one owed triangle behind the others
  task automatic owe_tri(input pia_tri_t t);
    tri_expected_q.insert(tri_expected_q.size(), t);
  endtask

  // triangles caused by one index item
  task automatic assemble_index(input logic [IndexBits-1:0] v, input logic start);
    logic [IndexBits-1:0] a;
    logic [IndexBits-1:0] b;
    if (start) begin
      slot_pos    = '0;
      winding_ccw = 1'b1;
    end
    case (face_mode)
      ModeList: begin
        if (slot_pos >= 2) begin
          owe_tri(pia_tri_t'{FieldBits'(held[0]), FieldBits'(held[1]),
                             FieldBits'(v), 1'b1});
          slot_pos = '0;
        end else begin
          held[slot_pos] = v;
          slot_pos       = slot_pos + 1'b1;
        end
      end
      ModeStrip: begin
        if (slot_pos < 2) begin
          held[slot_pos] = v;
          slot_pos       = slot_pos + 1'b1;
        end else begin
          a = held[0];
          b = held[1];
          // degenerate triangles are dropped but still slide the window
          if (a != b && b != v && v != a) begin
            if (winding_ccw) begin
              owe_tri(pia_tri_t'{FieldBits'(a), FieldBits'(v), FieldBits'(b), 1'b1});
            end else begin
              owe_tri(pia_tri_t'{FieldBits'(a), FieldBits'(b), FieldBits'(v), 1'b1});
            end
          end
          held[0]     = b;
          held[1]     = v;
          slot_pos    = 2'd2;
          winding_ccw = ~winding_ccw;
        end
      end
      ModeQuad: begin
        if (slot_pos == 2'd3) begin
          owe_tri(pia_tri_t'{FieldBits'(held[0]), FieldBits'(held[2]),
                             FieldBits'(held[1]), 1'b0});
          owe_tri(pia_tri_t'{FieldBits'(held[2]), FieldBits'(held[0]),
                             FieldBits'(v), 1'b1});
          slot_pos = '0;
        end else begin
          held[slot_pos] = v;
          slot_pos       = slot_pos + 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  // compare, then track config and predict at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    pia_tri_t want;
    if (!rst_ni) begin
      face_mode    = ModeList;
      held[0]      = '0;
      held[1]      = '0;
      held[2]      = '0;
      slot_pos     = '0;
      winding_ccw  = 1'b1;
      tri_expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (triangle_i.valid && triangle_i.ready) begin
        if (tri_expected_q.size() == 0) begin
          $error("unexpected triangle item %h %h %h run_last %b",
                 triangle_i.corner_first, triangle_i.corner_second,
                 triangle_i.corner_third, triangle_i.run_last);
          fail_count_o++;
        end else begin
          want = tri_expected_q.pop_front();
          if (triangle_i.corner_first !== want.corner_first) begin
            $error("corner_first expected %h actual %h",
                   want.corner_first, triangle_i.corner_first);
            fail_count_o++;
          end
          if (triangle_i.corner_second !== want.corner_second) begin
            $error("corner_second expected %h actual %h",
                   want.corner_second, triangle_i.corner_second);
            fail_count_o++;
          end
          if (triangle_i.corner_third !== want.corner_third) begin
            $error("corner_third expected %h actual %h",
                   want.corner_third, triangle_i.corner_third);
            fail_count_o++;
          end
          if (triangle_i.run_last !== want.run_last) begin
            $error("run_last expected %b actual %b", want.run_last, triangle_i.run_last);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        face_mode = pia_mode_e'(cfg_data_i);
      end
      if (index_i.valid && index_i.ready) begin
        assemble_index(index_i.vertex_index[IndexBits-1:0], index_i.list_start);
      end
      pending_o = tri_expected_q.size();
    end
  end

endmodule

FILE: tb/tb_primitive_index_assembler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_primitive_index_assembler_top
// drives vertex index items in list, strip, quad and unsupported face modes,
// first a directed set of corner cases, then random index lists with random
// gaps on both channels; the checker predicts and compares the triangles
// ----------------------------------------------------------------------------
module tb_primitive_index_assembler_top;
  import pia_pkg::*;

  // how the indices of one random list are chosen
  typedef enum int {
    FillRandom,
    FillSmall,
    FillExtreme,
    FillSequential
  } fill_e;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [ModeBits-1:0] cfg_data;
  int                  fail_count;
  int                  pending;
  int                  src_calm;
  int                  sink_calm;

  pia_in_if  idx_ch ();
  pia_out_if prim_ch ();

  primitive_index_assembler_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (idx_ch),
    .out_o      (prim_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  pia_triangle_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .index_i      (idx_ch),
    .triangle_i   (prim_ch),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // one index item, after a random gap
  task automatic send_index(input logic [FieldBits-1:0] vtx, input logic start);
    int gap;
    if (src_calm > 0) begin
      gap = 0;
      src_calm--;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 15) == 0) src_calm = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      idx_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    idx_ch.valid        <= 1'b1;
    idx_ch.vertex_index <= vtx;
    idx_ch.list_start   <= start;
    do @(posedge clk); while (!idx_ch.ready);
  endtask

  // stop sending and let every owed triangle out, then let the pipe settle
  task automatic wait_drained();
    int waited;
    @(negedge clk);
    idx_ch.valid <= 1'b0;
    for (waited = 0; waited < 5000 && pending != 0; waited++) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_face_mode(input pia_mode_e mode);
    wait_drained();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // receiver with random stalls between triangle items
  initial begin
    int stall;
    prim_ch.ready = 1'b0;
    sink_calm     = 0;
    @(posedge rst_n);
    forever begin
      if (sink_calm > 0) begin
        stall = 0;
        sink_calm--;
      end else begin
        stall = $urandom_range(0, 13);
        if ($urandom_range(0, 15) == 0) sink_calm = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        @(negedge clk);
        prim_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      prim_ch.ready <= 1'b1;
      do @(posedge clk); while (!(prim_ch.valid && prim_ch.ready));
    end
  end

  // stimulus and verdict
  initial begin
    logic [FieldBits-1:0] extreme_vtx [4];
    logic [FieldBits-1:0] base;
    logic [FieldBits-1:0] vtx;
    pia_mode_e            mode;
    fill_e                fill;
    int                   counted;
    int                   phase;
    int                   budget;
    int                   sent;
    int                   len;
    int                   k;
    logic                 carry;

    extreme_vtx         = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    idx_ch.valid        = 1'b0;
    idx_ch.vertex_index = '0;
    idx_ch.list_start   = 1'b0;
    src_calm            = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // list: extremes, an incomplete group dropped at the next list start
    set_face_mode(ModeList);
    send_index(32'hFFFF_FFFF, 1'b1);
    send_index(32'h0000_0000, 1'b0);
    send_index(32'h8000_0000, 1'b0);
    send_index(32'h0000_0001, 1'b0);
    send_index(32'h0000_0002, 1'b0);
    send_index(32'h7FFF_FFFF, 1'b1);
    send_index(32'h0000_0005, 1'b0);
    send_index(32'h0000_0006, 1'b0);

    // strip: each kind of degenerate triangle; both kept triangles take the first winding
    set_face_mode(ModeStrip);
    send_index(32'd10, 1'b1);
    send_index(32'd11, 1'b0);
    send_index(32'd12, 1'b0);
    send_index(32'd12, 1'b0);
    send_index(32'd13, 1'b0);
    send_index(32'd12, 1'b0);
    send_index(32'd14, 1'b0);

    // quad: one group of four
    set_face_mode(ModeQuad);
    send_index(32'd20, 1'b1);
    send_index(32'd21, 1'b0);
    send_index(32'd22, 1'b0);
    send_index(32'd23, 1'b0);

    // mode change inside a group keeps the position
    set_face_mode(ModeList);
    send_index(32'd30, 1'b1);
    send_index(32'd31, 1'b0);
    set_face_mode(ModeQuad);
    send_index(32'd32, 1'b0);
    send_index(32'd33, 1'b0);

    // unsupported mode ignores indices
    set_face_mode(ModeNone);
    send_index(32'd40, 1'b1);
    send_index(32'd41, 1'b0);

    // random phases, each with its own face mode
    counted = 0;
    phase   = 0;
    while (counted < 1800) begin
      mode = (phase < 4) ? pia_mode_e'(phase) : pia_mode_e'($urandom_range(0, 3));
      set_face_mode(mode);
      budget = (mode == ModeNone) ? 12 : $urandom_range(40, 120);
      carry  = ($urandom_range(0, 4) == 0);
      sent   = 0;
      while (sent < budget) begin
        if ($urandom_range(0, 6) != 0) begin
          // well formed list with random content
          fill = fill_e'($urandom_range(0, 3));
          base = $urandom;
          case (mode)
            ModeList:  len = 3 * $urandom_range(1, 4);
            ModeStrip: len = 2 + $urandom_range(1, 10);
            ModeQuad:  len = 4 * $urandom_range(1, 3);
            default:   len = $urandom_range(1, 6);
          endcase
          for (k = 0; k < len; k++) begin
            case (fill)
              FillRandom:  vtx = $urandom;
              FillSmall:   vtx = $urandom_range(0, 5);
              FillExtreme: vtx = extreme_vtx[$urandom_range(0, 3)];
              default:     vtx = base + k;
            endcase
            send_index(vtx, (k == 0) && !carry);
          end
          carry = 1'b0;
        end else begin
          // broken list: stray starts anywhere
          len = $urandom_range(1, 6);
          for (k = 0; k < len; k++) begin
            vtx = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5);
            send_index(vtx, $urandom_range(0, 3) == 0);
          end
        end
        sent += len;
      end
      if (mode != ModeNone) counted += sent;
      phase++;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/pia_pkg.sv
src/pia_in_if.sv
src/pia_out_if.sv
src/pia_assemble.sv
src/pia_result_queue.sv
src/primitive_index_assembler_top.sv
src/pia_checker.sv
tb/pia_triangle_checker.sv
tb/tb_primitive_index_assembler_top.sv
